@@ src/assert_macros.svh @@
// Assertion macros used by the top-level RTL file of the box average block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clk edge outside reset.
`define FWBA_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Condition that must never be true outside reset.
`define FWBA_ASSERT_NEVER(label, expr, msg) \
	`FWBA_ASSERT(label, !(expr), msg)

`endif

@@ src/fwba_pkg.sv @@
// Shared constants for the forward window box average block.
package fwba_pkg;

	localparam int WINDOW_MAX_DEF   = 10;
	localparam int SAMPLE_WIDTH_DEF = 16;
	localparam int CFG_W            = 4;

endpackage

@@ src/fwba_store.sv @@
// Sample store: circular buffer memory, one write and one registered read port.
module fwba_store
	import fwba_pkg::*;
#(
	parameter int WINDOW_MAX   = WINDOW_MAX_DEF,
	parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
	localparam int IDX_W       = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1
) (
	input  logic                           clk,
	input  logic                           wr_en,
	input  logic [IDX_W-1:0]               wr_addr,
	input  logic signed [SAMPLE_WIDTH-1:0] wr_data,
	input  logic                           rd_en,
	input  logic [IDX_W-1:0]               rd_addr,
	output logic signed [SAMPLE_WIDTH-1:0] rd_data
);

	logic [SAMPLE_WIDTH-1:0] store_q [WINDOW_MAX];
	logic [SAMPLE_WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			store_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= store_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

@@ src/fwba_div.sv @@
// Rounding divider: signed window total over 2..WINDOW_MAX+1 by reciprocal multiply.
module fwba_div
	import fwba_pkg::*;
#(
	parameter int WINDOW_MAX   = WINDOW_MAX_DEF,
	parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
	localparam int CNT_W       = $clog2(WINDOW_MAX + 1),
	localparam int TOT_W       = SAMPLE_WIDTH + CNT_W
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic signed [TOT_W-1:0]        total,
	input  logic [CNT_W-1:0]               n,
	output logic                           done,
	output logic signed [SAMPLE_WIDTH-1:0] mean
);

	// quotient = floor((2|t| + d) / 2d), d = n + 1, exact with a ceiling reciprocal
	localparam int NUM_W = TOT_W + 1;
	localparam int DEN_W = $clog2(2 * WINDOW_MAX + 3);
	localparam int SH    = NUM_W + DEN_W;
	localparam int R_W   = SH - 1;
	localparam int RL_W  = R_W / 2;
	localparam int RH_W  = R_W - RL_W;
	localparam int PL_W  = NUM_W + RL_W;
	localparam int PH_W  = NUM_W + RH_W;
	localparam int PR_W  = NUM_W + R_W;

	logic [R_W-1:0] recip_tbl [0:WINDOW_MAX];

	for (genvar g = 0; g <= WINDOW_MAX; g++) begin : g_recip
		localparam longint unsigned DEN = 2 * (g + 1);
		localparam longint unsigned RV  = ((64'd1 << SH) + DEN - 1) / DEN;
		assign recip_tbl[g] = R_W'(RV);
	end

	logic [TOT_W-1:0]        tot_u;
	logic [TOT_W-1:0]        mag_c;
	logic                    v_s1, v_s2, done_q;
	logic                    neg_s1, neg_s2;
	logic [NUM_W-1:0]        num_s1;
	logic [R_W-1:0]          recip_s1;
	logic [PL_W-1:0]         plo_s2;
	logic [PH_W-1:0]         phi_s2;
	logic [PR_W-1:0]         prod_c;
	logic [SAMPLE_WIDTH-1:0] quo_c;
	logic [SAMPLE_WIDTH-1:0] mean_q;

	always_comb begin
		tot_u = total;
		mag_c = total[TOT_W-1] ? (~tot_u + TOT_W'(1)) : tot_u;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
			done_q <= 1'b0;
		end else begin
			v_s1   <= start;
			v_s2   <= v_s1;
			done_q <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			neg_s1   <= total[TOT_W-1];
			num_s1   <= {mag_c, 1'b0} + NUM_W'(n) + NUM_W'(1);
			recip_s1 <= recip_tbl[n];
		end
		if (v_s1) begin
			neg_s2 <= neg_s1;
			plo_s2 <= PL_W'(num_s1) * PL_W'(recip_s1[RL_W-1:0]);
			phi_s2 <= PH_W'(num_s1) * PH_W'(recip_s1[R_W-1:RL_W]);
		end
		if (v_s2) begin
			mean_q <= neg_s2 ? (~quo_c + SAMPLE_WIDTH'(1)) : quo_c;
		end
	end

	always_comb begin
		prod_c = PR_W'(plo_s2) + (PR_W'(phi_s2) << RL_W);
		quo_c  = prod_c[SH +: SAMPLE_WIDTH];
	end

	assign done = done_q;
	assign mean = mean_q;

endmodule

@@ src/forward_window_box_average.sv @@
// Top level of the forward window box average: sequencer, running sum and output register.
`include "assert_macros.svh"

// Forward window box average. Each accepted sample x[i] yields, once its window
// x[i..i+W-1] has arrived, (x[i] + window sum) / (1 + window length) rounded to
// nearest, ties away from zero; the transaction carrying last_in flushes the list
// with shrinking windows and clears the store. W is window_size clamped to
// 1..WINDOW_MAX; window_size must be written only while the block is idle, which
// the block itself does not enforce. One item is handled at a time; each result
// passes through a store read, the three-stage reciprocal divider, the output load
// and a re-plan. After window_size has been lowered, a result whose window is
// shorter than the stored list first sums its window samples serially out of the
// store. A stall on the result side holds the sequencer at its output load. There
// is no clearing pass after reset.
module forward_window_box_average
	import fwba_pkg::*;
#(
	parameter int WINDOW_MAX   = WINDOW_MAX_DEF,
	parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           window_size_wr_en,
	input  logic [CFG_W-1:0]               window_size,
	input  logic                           sample_valid,
	output logic                           sample_stall,
	input  logic signed [SAMPLE_WIDTH-1:0] sample,
	input  logic                           last_in,
	output logic                           mean_valid,
	input  logic                           mean_stall,
	output logic signed [SAMPLE_WIDTH-1:0] mean,
	output logic                           last_out
);

	localparam int CNT_W = $clog2(WINDOW_MAX + 1);
	localparam int IDX_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
	localparam int AW    = IDX_W + 1;
	localparam int TOT_W = SAMPLE_WIDTH + CNT_W;

	typedef enum logic [6:0] {
		S_IDLE = 7'b0000001,
		S_PLAN = 7'b0000010,
		S_ACC  = 7'b0000100,
		S_ACCW = 7'b0001000,
		S_SUM  = 7'b0010000,
		S_DIV  = 7'b0100000,
		S_OUT  = 7'b1000000
	} state_t;

	function automatic logic [IDX_W-1:0] wrap_add(input logic [IDX_W-1:0] base,
			input logic [CNT_W-1:0] off);
		logic [AW-1:0] s;
		s = AW'(base) + AW'(off);
		if (s >= AW'(WINDOW_MAX)) begin
			s = s - AW'(WINDOW_MAX);
		end
		return s[IDX_W-1:0];
	endfunction

	state_t                         state_q;
	logic [CFG_W-1:0]               window_size_q;
	logic [IDX_W-1:0]               head_q;
	logic [CNT_W-1:0]               count_q;
	logic signed [TOT_W-1:0]        sum_q;
	logic signed [TOT_W-1:0]        acc_q;
	logic                           last_q;
	logic [CNT_W-1:0]               n_q;
	logic [CNT_W-1:0]               idx_q;
	logic                           mean_valid_q;
	logic signed [SAMPLE_WIDTH-1:0] mean_q;
	logic                           last_out_q;

	logic [CNT_W-1:0]               w_eff;
	logic                           emit_c;
	logic [CNT_W-1:0]               n_c;
	logic                           accept_c;
	logic                           load_c;
	logic                           mem_we;
	logic [IDX_W-1:0]               mem_waddr;
	logic                           mem_re;
	logic [IDX_W-1:0]               mem_raddr;
	logic signed [SAMPLE_WIDTH-1:0] mem_rdata;
	logic signed [TOT_W-1:0]        total_c;
	logic                           div_start;
	logic                           div_done;
	logic signed [SAMPLE_WIDTH-1:0] div_mean;

	always_comb begin
		if (window_size_q == '0) begin
			w_eff = CNT_W'(1);
		end else if (int'(window_size_q) > WINDOW_MAX) begin
			w_eff = CNT_W'(WINDOW_MAX);
		end else begin
			w_eff = CNT_W'(window_size_q);
		end
	end

	always_comb begin
		emit_c = 1'b0;
		n_c    = w_eff;
		if (count_q >= w_eff) begin
			emit_c = 1'b1;
		end else if (last_q && (count_q != '0)) begin
			emit_c = 1'b1;
			n_c    = count_q;
		end
	end

	assign accept_c  = sample_valid && !sample_stall;
	assign load_c    = (state_q == S_OUT) && (!mean_valid_q || !mean_stall);
	assign total_c   = acc_q + TOT_W'(mem_rdata);
	assign div_start = (state_q == S_SUM);

	assign mem_we    = accept_c;
	assign mem_waddr = wrap_add(head_q, count_q);

	always_comb begin
		mem_re    = 1'b0;
		mem_raddr = head_q;
		unique case (state_q)
			S_PLAN: begin
				mem_re = emit_c && (n_c >= count_q);
			end
			S_ACC: begin
				mem_re    = 1'b1;
				mem_raddr = wrap_add(head_q, idx_q);
			end
			S_ACCW: begin
				mem_re = ((idx_q + CNT_W'(1)) == n_q);
			end
			default: begin
				mem_re = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_size_q <= CFG_W'(1);
		end else if (window_size_wr_en) begin
			window_size_q <= window_size;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			head_q  <= '0;
			count_q <= '0;
			sum_q   <= '0;
			last_q  <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept_c) begin
						sum_q   <= sum_q + TOT_W'(sample);
						count_q <= count_q + CNT_W'(1);
						last_q  <= last_in;
						state_q <= S_PLAN;
					end
				end
				S_PLAN: begin
					if (emit_c) begin
						state_q <= (n_c >= count_q) ? S_SUM : S_ACC;
					end else begin
						if (last_q) begin
							last_q <= 1'b0;
							head_q <= '0;
						end
						state_q <= S_IDLE;
					end
				end
				S_ACC: begin
					state_q <= S_ACCW;
				end
				S_ACCW: begin
					state_q <= ((idx_q + CNT_W'(1)) == n_q) ? S_SUM : S_ACC;
				end
				S_SUM: begin
					sum_q   <= sum_q - TOT_W'(mem_rdata);
					head_q  <= wrap_add(head_q, CNT_W'(1));
					count_q <= count_q - CNT_W'(1);
					state_q <= S_DIV;
				end
				S_DIV: begin
					if (div_done) begin
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (load_c) begin
						state_q <= S_PLAN;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_PLAN) begin
			n_q   <= n_c;
			idx_q <= '0;
			acc_q <= (n_c >= count_q) ? sum_q : '0;
		end
		if (state_q == S_ACCW) begin
			acc_q <= total_c;
			idx_q <= idx_q + CNT_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mean_valid_q <= 1'b0;
		end else if (load_c) begin
			mean_valid_q <= 1'b1;
		end else if (!mean_stall) begin
			mean_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_c) begin
			mean_q     <= div_mean;
			last_out_q <= last_q && (count_q == '0);
		end
	end

	fwba_store #(
		.WINDOW_MAX   (WINDOW_MAX),
		.SAMPLE_WIDTH (SAMPLE_WIDTH)
	) u_store (
		.clk     (clk),
		.wr_en   (mem_we),
		.wr_addr (mem_waddr),
		.wr_data (sample),
		.rd_en   (mem_re),
		.rd_addr (mem_raddr),
		.rd_data (mem_rdata)
	);

	fwba_div #(
		.WINDOW_MAX   (WINDOW_MAX),
		.SAMPLE_WIDTH (SAMPLE_WIDTH)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.total  (total_c),
		.n      (n_q),
		.done   (div_done),
		.mean   (div_mean)
	);

	assign sample_stall = (state_q != S_IDLE);
	assign mean_valid   = mean_valid_q;
	assign mean         = mean_q;
	assign last_out     = last_out_q;

	`FWBA_ASSERT(a_count_bound, count_q <= CNT_W'(WINDOW_MAX), "store fill above WINDOW_MAX")
	`FWBA_ASSERT(a_sum_empty, (count_q == '0) |-> (sum_q == '0), "sum nonzero with empty store")
	`FWBA_ASSERT_NEVER(a_rw_overlap, mem_we && mem_re, "store written and read in one cycle")
	`FWBA_ASSERT(a_pop_nonempty, (state_q == S_SUM) |-> (count_q != '0), "pop from empty store")
	`FWBA_ASSERT(a_div_done, div_done |-> (state_q == S_DIV), "divider result while not waiting")

endmodule

@@ tb/forward_window_box_average_checker.sv @@
// Checker for the forward window box average: tracks window writes, predicts means, compares.
`timescale 1ns / 100ps

module forward_window_box_average_checker
	import fwba_pkg::*;
(
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               window_size_wr_en,
	input  logic [CFG_W-1:0]                   window_size,
	input  logic                               sample_valid,
	input  logic                               sample_stall,
	input  logic signed [SAMPLE_WIDTH_DEF-1:0] sample,
	input  logic                               last_in,
	input  logic                               mean_valid,
	input  logic                               mean_stall,
	input  logic signed [SAMPLE_WIDTH_DEF-1:0] mean,
	input  logic                               last_out,
	output int                                 failures,
	output int                                 pending,
	output int                                 checked
);

	localparam int SW   = SAMPLE_WIDTH_DEF;
	localparam int WMAX = WINDOW_MAX_DEF;

	typedef struct packed {
		logic signed [SW-1:0] mean;
		logic                 last_flag;
	} avg_result_t;

	avg_result_t          expected_means[$];
	avg_result_t          oldest;
	logic [CFG_W-1:0]     window_reg;
	logic signed [SW-1:0] held[WMAX];
	int                   held_sum;
	int                   held_count;

	function automatic logic signed [SW-1:0] rounded_mean(input int total, input int den);
		int mag;
		int q;
		mag = (total < 0) ? -total : total;
		q = (2 * mag + den) / (2 * den);
		return SW'((total < 0) ? -q : q);
	endfunction

	task automatic clear_window();
		for (int i = 0; i < WMAX; i++)
			held[i] = '0;
		held_sum = 0;
		held_count = 0;
	endtask

	// mean of the oldest held sample over its first span samples, then pop it
	task automatic emit_oldest_mean(input int span, output logic signed [SW-1:0] m);
		int total;
		int n;
		n = span;
		if (n >= held_count) begin
			n = held_count;
			total = held_sum;
		end else begin
			total = 0;
			for (int i = 0; i < n; i++)
				total += held[i];
		end
		total += held[0];
		m = rounded_mean(total, n + 1);
		held_sum -= held[0];
		for (int i = 0; i < WMAX - 1; i++)
			held[i] = held[i + 1];
		held[WMAX - 1] = '0;
		held_count--;
	endtask

	task automatic predict_means(input logic signed [SW-1:0] x, input logic lst);
		int                   w;
		int                   k;
		logic signed [SW-1:0] outs[WMAX];
		if (window_reg < 1)
			w = 1;
		else if (window_reg > WMAX)
			w = WMAX;
		else
			w = int'(window_reg);
		k = 0;
		if (held_count < WMAX) begin
			held[held_count] = x;
			held_sum += x;
			held_count++;
		end
		while (held_count >= w && held_count > 0 && k < WMAX) begin
			emit_oldest_mean(w, outs[k]);
			k++;
		end
		if (lst) begin
			// tail flush with shrinking windows
			while (held_count > 0 && k < WMAX) begin
				emit_oldest_mean(held_count, outs[k]);
				k++;
			end
			clear_window();
		end
		for (int j = 0; j < k; j++)
			expected_means.insert(expected_means.size(),
				avg_result_t'{mean: outs[j], last_flag: lst && (j == k - 1)});
	endtask

	always @(posedge clk) begin
		if (!arst_n) begin
			window_reg = 4'd1;
			clear_window();
			expected_means.delete();
		end else begin
			if (window_size_wr_en)
				window_reg = window_size;
			if (sample_valid && !sample_stall)
				predict_means(sample, last_in);
			if (mean_valid && !mean_stall) begin
				if (expected_means.size() == 0) begin
					$display("%0t: unexpected mean transaction, expected none, got mean %0d last %0b",
						$time, mean, last_out);
					failures++;
				end else begin
					oldest = expected_means.pop_front();
					if (oldest.mean !== mean) begin
						$display("%0t: mean mismatch, expected %0d, got %0d",
							$time, oldest.mean, mean);
						failures++;
					end
					if (oldest.last_flag !== last_out) begin
						$display("%0t: last_out mismatch, expected %0b, got %0b",
							$time, oldest.last_flag, last_out);
						failures++;
					end
					checked++;
				end
			end
		end
		pending = expected_means.size();
	end

endmodule

@@ tb/forward_window_box_average_test.sv @@
// Top of the forward window box average testbench: clock, reset, stimulus, verdict.
`timescale 1ns / 100ps

module forward_window_box_average_test
	import fwba_pkg::*;
();

	localparam int SW          = SAMPLE_WIDTH_DEF;
	localparam int ITEM_TARGET = 330;
	localparam int IDLE_GUARD  = 24;
	localparam int LONG_HOLD   = 400;

	logic                 clk;
	logic                 arst_n;
	logic                 window_size_wr_en;
	logic [CFG_W-1:0]     window_size;
	logic                 sample_valid;
	logic                 sample_stall;
	logic signed [SW-1:0] sample;
	logic                 last_in;
	logic                 mean_valid;
	logic                 mean_stall;
	logic signed [SW-1:0] mean;
	logic                 last_out;

	int        failures;
	int        pending;
	int        checked;
	int        items_sent;
	int        lists_closed;
	int        long_holds_asked;
	int        long_holds_done;
	bit        tx_quiet;
	bit        rx_quiet;
	bit [15:0] windows_used;

	forward_window_box_average uut (
		.clk               (clk),
		.arst_n            (arst_n),
		.window_size_wr_en (window_size_wr_en),
		.window_size       (window_size),
		.sample_valid      (sample_valid),
		.sample_stall      (sample_stall),
		.sample            (sample),
		.last_in           (last_in),
		.mean_valid        (mean_valid),
		.mean_stall        (mean_stall),
		.mean              (mean),
		.last_out          (last_out)
	);

	forward_window_box_average_checker checker_i (
		.clk               (clk),
		.arst_n            (arst_n),
		.window_size_wr_en (window_size_wr_en),
		.window_size       (window_size),
		.sample_valid      (sample_valid),
		.sample_stall      (sample_stall),
		.sample            (sample),
		.last_in           (last_in),
		.mean_valid        (mean_valid),
		.mean_stall        (mean_stall),
		.mean              (mean),
		.last_out          (last_out),
		.failures          (failures),
		.pending           (pending),
		.checked           (checked)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("FAIL forward_window_box_average");
		$finish;
	end

	// result side: random stall per transaction, plus a long hold-off on request
	initial begin
		int wait_left;
		int hold_left;
		bit took;
		mean_stall = 1'b0;
		wait_left = 0;
		hold_left = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			took = mean_valid && !mean_stall;
			@(negedge clk);
			if (long_holds_asked != long_holds_done) begin
				long_holds_done = long_holds_asked;
				hold_left = LONG_HOLD;
			end
			if (took)
				wait_left = rx_quiet ? 0 : $urandom_range(0, 19);
			if (hold_left > 0) begin
				hold_left--;
				mean_stall = 1'b1;
			end else if (wait_left > 0) begin
				wait_left--;
				mean_stall = 1'b1;
			end else begin
				mean_stall = 1'b0;
			end
		end
	end

	function automatic logic signed [SW-1:0] random_sample();
		case ($urandom_range(0, 7))
			0: return 16'sh7fff;
			1: return 16'sh8000;
			2: return SW'(int'($urandom_range(0, 8)) - 4);
			default: return SW'($urandom);
		endcase
	endfunction

	task automatic send_item(input logic signed [SW-1:0] x, input logic lst);
		int gap;
		gap = tx_quiet ? 0 : $urandom_range(0, 19);
		if (gap > 0) begin
			sample_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		sample = x;
		last_in = lst;
		sample_valid = 1'b1;
		@(posedge clk);
		while (sample_stall)
			@(posedge clk);
		@(negedge clk);
		items_sent++;
		if (lst)
			lists_closed++;
	endtask

	task automatic send_list(input int len, input bit closed);
		for (int i = 0; i < len; i++)
			send_item(random_sample(), closed && i == len - 1);
	endtask

	// wait until every expected mean has arrived and the block has gone quiet
	task automatic settle();
		sample_valid = 1'b0;
		do begin
			while (pending != 0)
				@(negedge clk);
			repeat (IDLE_GUARD) @(negedge clk);
		end while (pending != 0);
	endtask

	task automatic write_window(input logic [CFG_W-1:0] v);
		settle();
		window_size = v;
		window_size_wr_en = 1'b1;
		@(negedge clk);
		window_size_wr_en = 1'b0;
		windows_used[v] = 1'b1;
	endtask

	initial begin
		int  phase;
		int  n_lists;
		int  len;
		bit  open_tail;
		arst_n = 1'b0;
		window_size_wr_en = 1'b0;
		window_size = '0;
		sample_valid = 1'b0;
		sample = '0;
		last_in = 1'b0;
		tx_quiet = 1'b0;
		rx_quiet = 1'b0;
		windows_used = '0;
		repeat (11) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// reset window: one-element lists at the extremes
		send_item(16'sh7fff, 1'b1);
		send_item(16'sh8000, 1'b1);

		// zero acts as a window of one
		write_window(4'd0);
		send_item(16'sd100, 1'b0);
		send_item(-16'sd100, 1'b1);

		// above the maximum clamps to ten; list shorter than the window
		write_window(4'd15);
		send_item(16'sh7fff, 1'b0);
		send_item(16'sh7fff, 1'b0);
		send_item(16'sh8000, 1'b1);

		// rounding ties in both directions
		write_window(4'd3);
		send_item(16'sd1, 1'b0);
		send_item(16'sd0, 1'b0);
		send_item(16'sd0, 1'b0);
		send_item(-16'sd1, 1'b0);
		send_item(16'sd0, 1'b0);
		send_item(16'sd0, 1'b1);

		// window shrinks mid-list: several means leave on one transaction
		write_window(4'd10);
		send_item(16'sh8000, 1'b0);
		send_item(16'sh8000, 1'b0);
		send_item(16'sh7fff, 1'b0);
		send_item(random_sample(), 1'b0);
		send_item(random_sample(), 1'b0);
		write_window(4'd2);
		send_item(random_sample(), 1'b0);
		send_item(random_sample(), 1'b1);

		phase = 0;
		while (items_sent < ITEM_TARGET) begin
			if (phase == 0 || $urandom_range(0, 3) != 0)
				write_window(CFG_W'($urandom_range(0, 15)));
			else
				settle();
			tx_quiet = ($urandom_range(0, 3) == 0);
			rx_quiet = ($urandom_range(0, 3) == 0);
			if (phase == 4) begin
				// sender keeps offering while the result side holds off
				tx_quiet = 1'b1;
				long_holds_asked++;
				send_list(20, 1'b1);
			end
			n_lists = $urandom_range(1, 3);
			for (int j = 0; j < n_lists; j++) begin
				len = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : $urandom_range(1, 24);
				open_tail = (j == n_lists - 1) && ($urandom_range(0, 4) == 0);
				send_list(len, !open_tail);
			end
			phase++;
		end
		send_item(random_sample(), 1'b1);
		settle();
		repeat (40) @(negedge clk);

		$display("Run covered %0d sample transactions in %0d lists, %0d means checked,",
			items_sent, lists_closed, checked);
		$display("window settings written (bit mask by value): %04h, %0d phases", windows_used,
			phase);
		if (failures == 0 && pending == 0)
			$display("PASS forward_window_box_average");
		else
			$display("FAIL forward_window_box_average");
		$finish;
	end

endmodule

@@ filelist.f @@
+incdir+src
src/fwba_pkg.sv
src/fwba_store.sv
src/fwba_div.sv
src/forward_window_box_average.sv
tb/forward_window_box_average_checker.sv
tb/forward_window_box_average_test.sv
